### rtl/seg_isect_pkg.sv
// Shared constants, payload types and relation codes of the segment intersection block.
package seg_isect_pkg;

  // Geometry and fixed-point format.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 32;

  // Derived datapath widths.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 2;
  localparam int REM_W  = NUM_W + OUT_BITS;
  localparam int MUL_W  = OUT_BITS + DIFF_W;
  localparam int SUM_W  = MUL_W + 1;

  // Queue between the front and back parts.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [2:0] {
    REL_CROSS     = 3'd0,
    REL_COL_OVER  = 3'd1,
    REL_COL_APART = 3'd2,
    REL_PARALLEL  = 3'd3,
    REL_OUTSIDE   = 3'd4,
    REL_DEGEN     = 3'd5
  } rel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a1_x;
    logic signed [COORD_BITS-1:0] a1_y;
    logic signed [COORD_BITS-1:0] b1_x;
    logic signed [COORD_BITS-1:0] b1_y;
    logic signed [COORD_BITS-1:0] a2_x;
    logic signed [COORD_BITS-1:0] a2_y;
    logic signed [COORD_BITS-1:0] b2_x;
    logic signed [COORD_BITS-1:0] b2_y;
  } seg_in_t;

  typedef struct packed {
    logic                       hit;
    logic [2:0]                 relation;
    logic signed [OUT_BITS-1:0] point_x;
    logic signed [OUT_BITS-1:0] point_y;
    logic signed [OUT_BITS-1:0] param_first;
    logic signed [OUT_BITS-1:0] param_second;
    logic                       saturated;
  } seg_out_t;

  // Control that rides along with a job through the back part.
  typedef struct packed {
    logic                         hit;
    rel_t                         rel;
    logic                         do_div;
    logic                         use_r;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [DIFF_W-1:0]     rx;
    logic signed [DIFF_W-1:0]     ry;
  } seg_ctl_t;

  // One classified job as it sits in the queue.
  typedef struct packed {
    seg_ctl_t                  ctl;
    logic signed [NUM_W-1:0]   num_a;
    logic signed [NUM_W-1:0]   num_b;
    logic signed [NUM_W-1:0]   den;
  } seg_job_t;

endpackage

### rtl/segment_intersection_point.sv
// Top level of the two-segment intersection block.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     in_data  (seg_in_t)
//   out       output     out_valid / out_ready   out_data (seg_out_t)
//   cfg       input      cfg_we                  cfg_wdata (exclusive_ends)
//
// One pair is taken per cycle while credits remain; a result passes through the three front
// stages after the input register, the queue write and the 36-stage back pipeline whose 32
// one-bit divider stages dominate.
// Reset clears all valid bits, the queue and exclusive_ends; no clearing pass is needed.
// An output stall freezes the back pipeline; the front keeps filling the 8-entry queue
// until its credits run out, then in_ready drops.
module segment_intersection_point (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  seg_isect_pkg::seg_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output seg_isect_pkg::seg_out_t out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata
);
  import seg_isect_pkg::*;

  logic     exclusive_ends;
  logic     push;
  logic     pop;
  logic     empty;
  seg_job_t push_job;
  seg_job_t head_job;

  // End mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      exclusive_ends <= 1'b0;
    end else if (cfg_we) begin
      exclusive_ends <= cfg_wdata;
    end
  end

  seg_isect_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .exclusive_ends (exclusive_ends),
    .pop            (pop),
    .push           (push),
    .job            (push_job)
  );

  seg_isect_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .head      (head_job),
    .empty     (empty)
  );

  seg_isect_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/seg_isect_front.sv
// Front part: accepts segment pairs, forms cross and dot products and classifies them.
module seg_isect_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  seg_isect_pkg::seg_in_t in_data,
  input  logic                   exclusive_ends,
  input  logic                   pop,
  output logic                   push,
  output seg_isect_pkg::seg_job_t job
);
  import seg_isect_pkg::*;

  logic              accept;
  logic [QCNT_W-1:0] cnt;
  logic [QCNT_W-1:0] cnt_next;

  // Stage 1: differences.
  logic                         s1_v;
  logic signed [COORD_BITS-1:0] s1_a1x, s1_a1y, s1_a2x, s1_a2y;
  logic signed [DIFF_W-1:0]     s1_rx, s1_ry, s1_sx, s1_sy, s1_qx, s1_qy;

  // Stage 2: products.
  logic                         s2_v;
  logic                         s2_degen;
  logic signed [COORD_BITS-1:0] s2_a1x, s2_a1y, s2_a2x, s2_a2y;
  logic signed [DIFF_W-1:0]     s2_rx, s2_ry;
  logic signed [PROD_W-1:0]     p_rxsy, p_rysx, p_qxry, p_qyrx, p_qxsy, p_qysx;
  logic signed [PROD_W-1:0]     p_rxrx, p_ryry, p_qxrx, p_qyry, p_sxrx, p_syry;

  // Stage 3: sums.
  logic                         s3_v;
  logic                         s3_degen;
  logic signed [COORD_BITS-1:0] s3_a1x, s3_a1y, s3_a2x, s3_a2y;
  logic signed [DIFF_W-1:0]     s3_rx, s3_ry;
  logic signed [NUM_W-1:0]      s3_den, s3_n1, s3_n2, s3_rr, s3_d0, s3_d1;

  seg_job_t job_next;

  // Credits cover every job in the front stages and in the queue.
  assign in_ready = (cnt < QCNT_W'(QDEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    case ({accept, pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      push <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
      push <= s3_v;
    end
  end

  // Datapath stages advance every cycle.
  always_ff @(posedge clk) begin
    s1_a1x <= in_data.a1_x;
    s1_a1y <= in_data.a1_y;
    s1_a2x <= in_data.a2_x;
    s1_a2y <= in_data.a2_y;
    s1_rx  <= DIFF_W'(in_data.b1_x) - DIFF_W'(in_data.a1_x);
    s1_ry  <= DIFF_W'(in_data.b1_y) - DIFF_W'(in_data.a1_y);
    s1_sx  <= DIFF_W'(in_data.b2_x) - DIFF_W'(in_data.a2_x);
    s1_sy  <= DIFF_W'(in_data.b2_y) - DIFF_W'(in_data.a2_y);
    s1_qx  <= DIFF_W'(in_data.a2_x) - DIFF_W'(in_data.a1_x);
    s1_qy  <= DIFF_W'(in_data.a2_y) - DIFF_W'(in_data.a1_y);

    s2_degen <= (s1_rx == '0) && (s1_ry == '0);
    s2_a1x   <= s1_a1x;
    s2_a1y   <= s1_a1y;
    s2_a2x   <= s1_a2x;
    s2_a2y   <= s1_a2y;
    s2_rx    <= s1_rx;
    s2_ry    <= s1_ry;
    p_rxsy   <= s1_rx * s1_sy;
    p_rysx   <= s1_ry * s1_sx;
    p_qxry   <= s1_qx * s1_ry;
    p_qyrx   <= s1_qy * s1_rx;
    p_qxsy   <= s1_qx * s1_sy;
    p_qysx   <= s1_qy * s1_sx;
    p_rxrx   <= s1_rx * s1_rx;
    p_ryry   <= s1_ry * s1_ry;
    p_qxrx   <= s1_qx * s1_rx;
    p_qyry   <= s1_qy * s1_ry;
    p_sxrx   <= s1_sx * s1_rx;
    p_syry   <= s1_sy * s1_ry;

    s3_degen <= s2_degen;
    s3_a1x   <= s2_a1x;
    s3_a1y   <= s2_a1y;
    s3_a2x   <= s2_a2x;
    s3_a2y   <= s2_a2y;
    s3_rx    <= s2_rx;
    s3_ry    <= s2_ry;
    s3_den   <= NUM_W'(p_rxsy) - NUM_W'(p_rysx);
    s3_n2    <= NUM_W'(p_qxry) - NUM_W'(p_qyrx);
    s3_n1    <= NUM_W'(p_qxsy) - NUM_W'(p_qysx);
    s3_rr    <= NUM_W'(p_rxrx) + NUM_W'(p_ryry);
    s3_d0    <= NUM_W'(p_qxrx) + NUM_W'(p_qyry);
    s3_d1    <= NUM_W'(p_qxrx) + NUM_W'(p_qyry) + NUM_W'(p_sxrx) + NUM_W'(p_syry);

    job <= job_next;
  end

  // Stage 4: exact classification of the pair.
  always_comb begin
    logic                    col, den_z, den_neg, d0_lt;
    logic signed [NUM_W-1:0] lo, hi;
    logic                    ov, in1, in2;

    den_z   = (s3_den == '0);
    den_neg = s3_den[NUM_W-1];
    col     = den_z && (s3_n2 == '0);
    d0_lt   = (s3_d0 < s3_d1);
    lo      = d0_lt ? s3_d0 : s3_d1;
    hi      = d0_lt ? s3_d1 : s3_d0;

    if (exclusive_ends) begin
      ov = (lo < s3_rr) && (hi > 0) && (s3_d0 != s3_d1);
    end else begin
      ov = (lo <= s3_rr) && (hi >= 0);
    end

    // Parameter range tests written for either sign of the denominator.
    if (exclusive_ends) begin
      in1 = den_neg ? ((s3_n1 < 0) && (s3_n1 > s3_den)) : ((s3_n1 > 0) && (s3_n1 < s3_den));
      in2 = den_neg ? ((s3_n2 < 0) && (s3_n2 > s3_den)) : ((s3_n2 > 0) && (s3_n2 < s3_den));
    end else begin
      in1 = den_neg ? ((s3_n1 <= 0) && (s3_n1 >= s3_den))
                    : ((s3_n1 >= 0) && (s3_n1 <= s3_den));
      in2 = den_neg ? ((s3_n2 <= 0) && (s3_n2 >= s3_den))
                    : ((s3_n2 >= 0) && (s3_n2 <= s3_den));
    end

    job_next            = '0;
    job_next.ctl.rx     = s3_rx;
    job_next.ctl.ry     = s3_ry;
    job_next.ctl.base_x = s3_a1x;
    job_next.ctl.base_y = s3_a1y;

    if (s3_degen) begin
      job_next.ctl.rel = REL_DEGEN;
    end else if (col) begin
      if (ov) begin
        job_next.ctl.hit    = 1'b1;
        job_next.ctl.rel    = REL_COL_OVER;
        job_next.ctl.do_div = 1'b1;
        job_next.ctl.base_x = s3_a2x;
        job_next.ctl.base_y = s3_a2y;
        job_next.num_a      = s3_d0;
        job_next.num_b      = s3_d1;
        job_next.den        = s3_rr;
      end else begin
        job_next.ctl.rel = REL_COL_APART;
      end
    end else if (den_z) begin
      job_next.ctl.rel = REL_PARALLEL;
    end else begin
      job_next.ctl.hit    = in1 && in2;
      job_next.ctl.rel    = (in1 && in2) ? REL_CROSS : REL_OUTSIDE;
      job_next.ctl.do_div = 1'b1;
      job_next.ctl.use_r  = 1'b1;
      job_next.num_a      = s3_n1;
      job_next.num_b      = s3_n2;
      job_next.den        = s3_den;
    end
  end

endmodule

### rtl/seg_isect_fifo.sv
// Short job queue between the front and back parts.
module seg_isect_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  seg_isect_pkg::seg_job_t push_data,
  input  logic                    pop,
  output seg_isect_pkg::seg_job_t head,
  output logic                    empty
);
  import seg_isect_pkg::*;

  seg_job_t          mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill count; the front's credits keep pushes within depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/seg_isect_back.sv
// Back part: pipelined division of both parameters, point reconstruction and output register.
module seg_isect_back (
  input  logic                    clk,
  input  logic                    rst,
  input  seg_isect_pkg::seg_job_t job,
  input  logic                    empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output seg_isect_pkg::seg_out_t out_data
);
  import seg_isect_pkg::*;

  localparam logic [OUT_BITS-1:0] MAG_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] NEG_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic en;

  // Divider pipeline: index k holds a job with k quotient bits resolved.
  logic              dvld [0:OUT_BITS];
  seg_ctl_t          dctl [0:OUT_BITS];
  logic [REM_W-1:0]  rem  [0:OUT_BITS][0:1];
  logic [NUM_W-1:0]  dv   [0:OUT_BITS][0:1];
  logic [OUT_BITS-1:0] qt [0:OUT_BITS][0:1];
  logic              neg  [0:OUT_BITS][0:1];
  logic              ovf  [0:OUT_BITS][0:1];

  logic [REM_W-1:0]    rem_n [1:OUT_BITS][0:1];
  logic [OUT_BITS-1:0] qt_n  [1:OUT_BITS][0:1];

  // Setup values from the queue head.
  logic [REM_W-1:0] set_rem [0:1];
  logic [NUM_W-1:0] set_dv  [0:1];
  logic             set_neg [0:1];
  logic             set_ovf [0:1];

  // Finish stage.
  logic                       f_vld;
  seg_ctl_t                   f_ctl;
  logic signed [OUT_BITS-1:0] f_par [0:1];
  logic                       f_sat;
  logic signed [OUT_BITS-1:0] fin_par [0:1];
  logic                       fin_sat;

  // Multiply stage.
  logic                       m_vld;
  seg_ctl_t                   m_ctl;
  logic signed [OUT_BITS-1:0] m_par [0:1];
  logic                       m_sat;
  logic signed [MUL_W-1:0]    m_px, m_py;

  // Point sums.
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic signed [OUT_BITS-1:0] pt_x, pt_y;
  logic                       sat_x, sat_y;

  // The whole back pipeline moves together whenever the output can take a job.
  assign en        = !out_valid || out_ready;
  assign pop       = !empty && en;

  // Magnitudes, sign and overflow test of each quotient.
  always_comb begin
    logic [NUM_W-1:0] un, ud;
    logic signed [NUM_W-1:0] nm;
    for (int l = 0; l < 2; l++) begin
      nm = (l == 0) ? job.num_a : job.num_b;
      un = nm[NUM_W-1] ? NUM_W'(-nm) : NUM_W'(nm);
      ud = job.den[NUM_W-1] ? NUM_W'(-job.den) : NUM_W'(job.den);
      set_neg[l] = nm[NUM_W-1] ^ job.den[NUM_W-1];
      set_ovf[l] = REM_W'(un) >= (REM_W'(ud) << (OUT_BITS - FRAC_BITS));
      set_rem[l] = REM_W'(un) << FRAC_BITS;
      set_dv[l]  = ud;
    end
  end

  // One restoring quotient bit per stage, most significant first.
  always_comb begin
    logic [REM_W-1:0] shd;
    logic             ge;
    for (int k = 1; k <= OUT_BITS; k++) begin
      for (int l = 0; l < 2; l++) begin
        shd = REM_W'(dv[k-1][l]) << (OUT_BITS - k);
        ge  = rem[k-1][l] >= shd;
        rem_n[k][l] = ge ? rem[k-1][l] - shd : rem[k-1][l];
        qt_n[k][l]  = qt[k-1][l] | (OUT_BITS'(ge) << (OUT_BITS - k));
      end
    end
  end

  // Signed, clamped parameters from the finished quotients.
  always_comb begin
    logic [OUT_BITS-1:0] q;
    logic                sat_l;
    fin_sat = 1'b0;
    for (int l = 0; l < 2; l++) begin
      q     = qt[OUT_BITS][l];
      sat_l = ovf[OUT_BITS][l] ||
              ((q > MAG_MAX) && !(neg[OUT_BITS][l] && (q == NEG_MIN)));
      if (!dctl[OUT_BITS].do_div) begin
        fin_par[l] = '0;
      end else if (sat_l) begin
        fin_par[l] = neg[OUT_BITS][l] ? NEG_MIN : MAG_MAX;
      end else begin
        fin_par[l] = neg[OUT_BITS][l] ? -q : q;
      end
      fin_sat = fin_sat || (dctl[OUT_BITS].do_div && sat_l);
    end
  end

  // Point as base times one plus, where use_r is set, the first parameter times the first segment.
  always_comb begin
    sum_x = (SUM_W'(m_ctl.base_x) <<< FRAC_BITS) + (m_ctl.use_r ? SUM_W'(m_px) : '0);
    sum_y = (SUM_W'(m_ctl.base_y) <<< FRAC_BITS) + (m_ctl.use_r ? SUM_W'(m_py) : '0);
    sat_x = (sum_x[SUM_W-1:OUT_BITS-1] != '0) && (sum_x[SUM_W-1:OUT_BITS-1] != '1);
    sat_y = (sum_y[SUM_W-1:OUT_BITS-1] != '0) && (sum_y[SUM_W-1:OUT_BITS-1] != '1);
    pt_x  = sat_x ? (sum_x[SUM_W-1] ? NEG_MIN : MAG_MAX) : sum_x[OUT_BITS-1:0];
    pt_y  = sat_y ? (sum_y[SUM_W-1] ? NEG_MIN : MAG_MAX) : sum_y[OUT_BITS-1:0];
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= OUT_BITS; k++) begin
        dvld[k] <= 1'b0;
      end
      f_vld     <= 1'b0;
      m_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      dvld[0] <= pop;
      for (int k = 1; k <= OUT_BITS; k++) begin
        dvld[k] <= dvld[k-1];
      end
      f_vld     <= dvld[OUT_BITS];
      m_vld     <= f_vld;
      out_valid <= m_vld;
    end
  end

  // Payload of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      dctl[0] <= job.ctl;
      for (int l = 0; l < 2; l++) begin
        rem[0][l] <= set_rem[l];
        dv[0][l]  <= set_dv[l];
        qt[0][l]  <= '0;
        neg[0][l] <= set_neg[l];
        ovf[0][l] <= set_ovf[l];
      end
      for (int k = 1; k <= OUT_BITS; k++) begin
        dctl[k] <= dctl[k-1];
        for (int l = 0; l < 2; l++) begin
          rem[k][l] <= rem_n[k][l];
          dv[k][l]  <= dv[k-1][l];
          qt[k][l]  <= qt_n[k][l];
          neg[k][l] <= neg[k-1][l];
          ovf[k][l] <= ovf[k-1][l];
        end
      end

      f_ctl    <= dctl[OUT_BITS];
      f_par[0] <= fin_par[0];
      f_par[1] <= fin_par[1];
      f_sat    <= fin_sat;

      m_ctl    <= f_ctl;
      m_par[0] <= f_par[0];
      m_par[1] <= f_par[1];
      m_sat    <= f_sat;
      m_px     <= f_par[0] * f_ctl.rx;
      m_py     <= f_par[0] * f_ctl.ry;

      out_data.hit          <= m_ctl.hit;
      out_data.relation     <= m_ctl.rel;
      out_data.point_x      <= m_ctl.hit ? pt_x : '0;
      out_data.point_y      <= m_ctl.hit ? pt_y : '0;
      out_data.param_first  <= m_par[0];
      out_data.param_second <= m_par[1];
      out_data.saturated    <= m_sat || (m_ctl.hit && (sat_x || sat_y));
    end
  end

endmodule

### dv/segment_intersection_point_checker.sv
// Checker that predicts segment intersection results and compares them at the output.
`timescale 1ns / 100ps

module segment_intersection_point_checker
  import seg_isect_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  seg_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  seg_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  output int       fail_count,
  output int       pending
);

  seg_out_t expected_results[$];
  logic     excl_mode;

  // Fixed-point quotient truncated toward zero, clamped to 32 bits.
  function automatic logic signed [31:0] fx_quotient(longint num, longint dvs,
                                                     ref logic sat);
    logic     neg;
    longint   un, ud, ip, rem, frac, m, lim;
    if (dvs == 0) return 32'sd0;
    neg = (num < 0) != (dvs < 0);
    un = num < 0 ? -num : num;
    ud = dvs < 0 ? -dvs : dvs;
    ip = un / ud;
    rem = un % ud;
    frac = 0;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (ip >= (64'sd1 << (32 - FRAC_BITS))) begin
      sat = 1'b1;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        frac = frac | 1;
      end
    end
    m = (ip << FRAC_BITS) | frac;
    if (m > lim) begin
      sat = 1'b1;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return neg ? 32'(-m) : 32'(m);
  endfunction

  function automatic logic signed [31:0] fx_clamp(longint v, ref logic sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  // Classify one segment pair and compute its reported values.
  function automatic seg_out_t intersect_pair(seg_in_t s, logic excl);
    seg_out_t r;
    longint   a1x, a1y, a2x, a2y, rx, ry, sx, sy, qx, qy, den, n1, n2, one;
    longint   rr, d0, d1, lo, hi;
    logic     sat, ov, in1, in2;
    r = '0;
    sat = 1'b0;
    one = 64'sd1 << FRAC_BITS;
    a1x = s.a1_x; a1y = s.a1_y; a2x = s.a2_x; a2y = s.a2_y;
    rx = longint'(s.b1_x) - a1x; ry = longint'(s.b1_y) - a1y;
    sx = longint'(s.b2_x) - a2x; sy = longint'(s.b2_y) - a2y;
    qx = a2x - a1x; qy = a2y - a1y;
    den = rx * sy - ry * sx;
    n2 = qx * ry - qy * rx;
    if (rx == 0 && ry == 0) begin
      r.relation = REL_DEGEN;
    end else if (den == 0 && n2 == 0) begin
      rr = rx * rx + ry * ry;
      d0 = qx * rx + qy * ry;
      d1 = d0 + sx * rx + sy * ry;
      lo = d0 < d1 ? d0 : d1;
      hi = d0 < d1 ? d1 : d0;
      ov = excl ? (lo < rr && hi > 0 && d0 != d1) : (lo <= rr && hi >= 0);
      if (ov) begin
        r.hit = 1'b1;
        r.relation = REL_COL_OVER;
        r.param_first = fx_quotient(d0, rr, sat);
        r.param_second = fx_quotient(d1, rr, sat);
        r.point_x = fx_clamp(a2x * one, sat);
        r.point_y = fx_clamp(a2y * one, sat);
      end else begin
        r.relation = REL_COL_APART;
      end
    end else if (den == 0) begin
      r.relation = REL_PARALLEL;
    end else begin
      n1 = qx * sy - qy * sx;
      if (den < 0) begin
        den = -den; n1 = -n1; n2 = -n2;
      end
      if (excl) begin
        in1 = n1 > 0 && n1 < den;
        in2 = n2 > 0 && n2 < den;
      end else begin
        in1 = n1 >= 0 && n1 <= den;
        in2 = n2 >= 0 && n2 <= den;
      end
      r.param_first = fx_quotient(n1, den, sat);
      r.param_second = fx_quotient(n2, den, sat);
      if (in1 && in2) begin
        r.hit = 1'b1;
        r.relation = REL_CROSS;
        r.point_x = fx_clamp(a1x * one + longint'(r.param_first) * rx, sat);
        r.point_y = fx_clamp(a1y * one + longint'(r.param_first) * ry, sat);
      end else begin
        r.relation = REL_OUTSIDE;
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  assign pending = expected_results.size();

  // Track the mode, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    seg_out_t want;
    if (rst) begin
      excl_mode <= 1'b0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) excl_mode <= cfg_wdata;
      if (in_valid && in_ready) expected_results.push_back(intersect_pair(in_data, excl_mode));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10) $display("expected %p actual %p", want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### dv/segment_intersection_point_tb.sv
// Testbench top: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module segment_intersection_point_tb;
  import seg_isect_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0, in_ready;
  seg_in_t  in_data = '0;
  logic     out_valid, out_ready = 1'b0;
  seg_out_t out_data;
  logic     cfg_we = 1'b0, cfg_wdata = 1'b0;
  int       fail_count, pending;
  int       send_idle = 0, recv_stall = 0;
  logic     hold_start = 1'b0;
  logic     hold_off = 1'b0;
  int       hold_count = 0;
  longint   cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_point u_top (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  segment_intersection_point_checker u_chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_wdata, .fail_count, .pending
  );

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("segment_intersection_point: mismatch");
      $finish;
    end
  end

  // Receiver stalls at random, or holds off for a counted stretch.
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      if (hold_count >= 300) begin
        hold_off <= 1'b0;
        hold_count <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (hold_start) begin
      hold_off <= 1'b1;
      hold_count <= 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic signed [15:0] rand_coord(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 20) - 10);
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // Transfer one pair, with optional random gap in front.
  task automatic send_pair(seg_in_t s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_mode(logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic seg_in_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_in_t s;
    s.a1_x = 16'(a); s.a1_y = 16'(b); s.b1_x = 16'(c); s.b1_y = 16'(d);
    s.a2_x = 16'(e); s.a2_y = 16'(f); s.b2_x = 16'(g); s.b2_y = 16'(h);
    return s;
  endfunction

  // Random pair biased toward collinear, parallel, touching and degenerate cases.
  function automatic seg_in_t rand_pair();
    seg_in_t s;
    int      kind, k;
    kind = $urandom_range(2);
    s = {rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind),
         rand_coord(kind), rand_coord(kind), rand_coord(kind), rand_coord(kind)};
    case ($urandom_range(5))
      0: begin
        k = $urandom_range(0, 6) - 2;
        s.a2_x = 16'(s.a1_x + k * (s.b1_x - s.a1_x));
        s.a2_y = 16'(s.a1_y + k * (s.b1_y - s.a1_y));
        k = $urandom_range(0, 6) - 2;
        s.b2_x = 16'(s.a1_x + k * (s.b1_x - s.a1_x));
        s.b2_y = 16'(s.a1_y + k * (s.b1_y - s.a1_y));
      end
      1: begin
        s.b2_x = 16'(s.a2_x + (s.b1_x - s.a1_x));
        s.b2_y = 16'(s.a2_y + (s.b1_y - s.a1_y));
      end
      2: begin
        s.a2_x = s.b1_x;
        s.a2_y = s.b1_y;
      end
      3: begin
        s.b1_x = s.a1_x;
        s.b1_y = s.a1_y;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic directed_pairs();
    send_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(mk(0, 0, 10, 0, 10, 0, 10, 5));
    send_pair(mk(0, 0, 10, 0, 0, 0, 0, 5));
    send_pair(mk(3, 3, 3, 3, 0, 0, 5, 5));
    send_pair(mk(0, 0, 10, 0, 5, 0, 20, 0));
    send_pair(mk(0, 0, 10, 0, 10, 0, 20, 0));
    send_pair(mk(0, 0, 10, 0, 11, 0, 20, 0));
    send_pair(mk(0, 0, 10, 0, 4, 0, 4, 0));
    send_pair(mk(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(mk(0, 0, 1, 1, 5, 0, 5, 1));
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk(0, 0, 1, 0, 32767, -1, 32767, 1));
    send_pair(mk(0, 0, 1, 0, -32768, -1, -32768, 1));
    send_pair(mk(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767));
    send_pair(mk(-32768, 0, 32767, 0, -32768, 0, 32767, 0));
    send_pair(mk(0, 0, 2, 2, 0, 2, 2, 0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_pairs();
    go_idle();
    set_mode(1'b1);
    directed_pairs();
    go_idle();
    set_mode(1'b0);
    // Random phases: no idling, sender idle, receiver stalls, both.
    for (int ph = 0; ph < 8; ph++) begin
      send_idle = (ph % 4 == 1) ? 50 : (ph % 4 == 3) ? 26 : 0;
      recv_stall = (ph % 4 == 2) ? 50 : (ph % 4 == 3) ? 26 : 0;
      // Start a long receiver hold-off while the sender keeps offering.
      if (ph == 4) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      for (int i = 0; i < 48; i++) begin
        send_pair(rand_pair());
      end
      go_idle();
      set_mode(ph[0]);
    end
    if (fail_count == 0) begin
      $display("segment_intersection_point: match");
    end else begin
      $display("segment_intersection_point: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/seg_isect_pkg.sv
rtl/seg_isect_front.sv
rtl/seg_isect_fifo.sv
rtl/seg_isect_back.sv
rtl/segment_intersection_point.sv
dv/segment_intersection_point_checker.sv
dv/segment_intersection_point_tb.sv
